@@ hdl/tarrc_pkg.sv @@
package tarrc_pkg;

    // Fixed-point formats
    localparam int FRACTION_BITS       = 8;
    localparam int ANGLE_FRACTION_BITS = 4;

    // Widths of the internal speed path
    localparam int SPEED_W = 18;
    localparam int WANT_W  = 8 + FRACTION_BITS + 1;
    localparam int STEP_SHL = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
    localparam int STEP_SHR = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;
    localparam int STEP_W  = 32 + STEP_SHL;
    localparam int SUM_W   = STEP_W + 2;

    // Speed saturation and snap window
    localparam int SPEED_LIMIT_RAW = 255 * (1 << FRACTION_BITS);
    localparam int SPEED_LIMIT = (SPEED_LIMIT_RAW > 131071) ? 131071 : SPEED_LIMIT_RAW;
    localparam int SNAP_WINDOW = 5 * (1 << FRACTION_BITS);

    // Common angle width for both axes (azimuth is the wider one)
    localparam int ANGLE_W = 14;

    // Azimuth wrap constants
    localparam int DEG_HALF_TURN = 180;
    localparam int DEG_FULL_TURN = 360;
    localparam int WRAP_OFFSET   = 92 * DEG_FULL_TURN;
    // Reciprocal of a full turn; the quotient is exact for offset values below 2^17
    localparam int WRAP_SHIFT    = 25;
    localparam int WRAP_RECIP    = (1 << WRAP_SHIFT) / DEG_FULL_TURN + 1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_ESTOP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_AZ_MAX_DRIVE     = 3'd0,
        REG_EL_MAX_DRIVE     = 3'd1,
        REG_AZ_RAMP_RATE     = 3'd2,
        REG_EL_RAMP_RATE     = 3'd3,
        REG_AZ_HALF_DEADBAND = 3'd4,
        REG_EL_HALF_DEADBAND = 3'd5,
        REG_EL_LOWER_LIMIT   = 3'd6,
        REG_EL_UPPER_LIMIT   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  max_drive;
        logic [15:0] ramp_rate;
        logic [11:0] half_deadband;
    } axis_cfg_t;

    // Wrap whole degrees into -180..180, keeping the half-turn edge on the
    // side the value came from.
    function automatic logic signed [8:0] wrap_deg(input logic signed [15:0] a);
        logic [16:0]        v;
        logic [33:0]        prod;
        logic [7:0]         q;
        logic signed [9:0]  r;
        logic signed [8:0]  res;
        v    = 17'(32'(a) + WRAP_OFFSET);
        prod = 34'(v) * 34'(WRAP_RECIP);
        q    = prod[WRAP_SHIFT +: 8];
        r    = $signed(10'(v - 17'(q) * 17'(DEG_FULL_TURN)));
        if (a > 16'(DEG_HALF_TURN)) begin
            res = (r > 10'(DEG_HALF_TURN)) ? 9'(r - 10'(DEG_FULL_TURN)) : 9'(r);
        end else if (a < -16'(DEG_HALF_TURN)) begin
            res = (r >= 10'(DEG_HALF_TURN)) ? 9'(r - 10'(DEG_FULL_TURN)) : 9'(r);
        end else begin
            res = 9'(a);
        end
        return res;
    endfunction

endpackage

@@ hdl/tarrc_axis_ramp.sv @@
module tarrc_axis_ramp (
    input  logic                                  movement_off,
    input  logic signed [tarrc_pkg::ANGLE_W-1:0]  cur_angle,
    input  logic signed [tarrc_pkg::ANGLE_W-1:0]  goal_angle,
    input  logic [15:0]                           elapsed_ms,
    input  tarrc_pkg::axis_cfg_t                  cfg,
    input  logic signed [tarrc_pkg::SPEED_W-1:0]  speed,
    output logic signed [tarrc_pkg::SPEED_W-1:0]  speed_next
);

    localparam int CMP_W = tarrc_pkg::ANGLE_W + 1;

    logic signed [tarrc_pkg::WANT_W-1:0] full;
    logic signed [tarrc_pkg::WANT_W-1:0] wanted;
    logic signed [CMP_W-1:0]             cur_lo;
    logic signed [CMP_W-1:0]             cur_hi;
    logic signed [CMP_W-1:0]             goal_x;
    logic [31:0]                         product;
    logic [tarrc_pkg::STEP_W-1:0]        step;
    logic signed [tarrc_pkg::SUM_W-1:0]  speed_x;
    logic signed [tarrc_pkg::SUM_W-1:0]  wanted_x;
    logic signed [tarrc_pkg::SUM_W-1:0]  stepped;
    logic signed [tarrc_pkg::SUM_W-1:0]  clamped;
    logic signed [tarrc_pkg::SUM_W-1:0]  diff;
    logic signed [tarrc_pkg::SUM_W-1:0]  diff_abs;

    localparam logic signed [tarrc_pkg::SUM_W-1:0] LIM_POS = tarrc_pkg::SPEED_LIMIT;
    localparam logic signed [tarrc_pkg::SUM_W-1:0] LIM_NEG = -tarrc_pkg::SPEED_LIMIT;
    localparam logic signed [tarrc_pkg::SUM_W-1:0] SNAP    = tarrc_pkg::SNAP_WINDOW;

    // Wanted drive from the deadband test
    assign full   = $signed(tarrc_pkg::WANT_W'({cfg.max_drive,
                                               {tarrc_pkg::FRACTION_BITS{1'b0}}}));
    assign cur_lo = CMP_W'(cur_angle) - $signed(CMP_W'(cfg.half_deadband));
    assign cur_hi = CMP_W'(cur_angle) + $signed(CMP_W'(cfg.half_deadband));
    assign goal_x = CMP_W'(goal_angle);

    always_comb begin
        priority if (movement_off) begin
            wanted = '0;
        end else if (cur_lo > goal_x) begin
            wanted = -full;
        end else if (cur_hi < goal_x) begin
            wanted = full;
        end else begin
            wanted = '0;
        end
    end

    // Step toward the wanted speed, saturate, then snap when close
    assign product  = 32'(cfg.ramp_rate) * 32'(elapsed_ms);
    assign step     = (tarrc_pkg::STEP_W'(product) << tarrc_pkg::STEP_SHL)
                      >> tarrc_pkg::STEP_SHR;
    assign speed_x  = tarrc_pkg::SUM_W'(speed);
    assign wanted_x = tarrc_pkg::SUM_W'(wanted);

    always_comb begin
        if (wanted_x > speed_x) begin
            stepped = speed_x + $signed({2'b00, step});
        end else begin
            stepped = speed_x - $signed({2'b00, step});
        end

        priority if (stepped > LIM_POS) begin
            clamped = LIM_POS;
        end else if (stepped < LIM_NEG) begin
            clamped = LIM_NEG;
        end else begin
            clamped = stepped;
        end

        diff     = wanted_x - clamped;
        diff_abs = (diff < 0) ? -diff : diff;

        priority if (wanted_x == speed_x) begin
            speed_next = speed;
        end else if (diff_abs < SNAP) begin
            speed_next = tarrc_pkg::SPEED_W'(wanted_x);
        end else begin
            speed_next = tarrc_pkg::SPEED_W'(clamped);
        end
    end

endmodule

@@ hdl/two_axis_rotator_ramp_control.sv @@
// Each accepted beat is registered at the input, its result at the output.
// Throughput: one beat per cycle; both axis updates and the goal handling
// finish in the single compute stage behind the input register.
// A stall on m_tready holds the output register and backs up into s_tready.
// Reset (aresetn low, synchronous): pipeline empty, state zero, goal not
// loaded, movement enabled, configuration at its documented defaults.
module two_axis_rotator_ramp_control (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] measured_azimuth, [24:13] measured_elevation, [40:25] elapsed_ms,
    // [56:41] wanted_azimuth, [72:57] wanted_elevation, [79:73] zero
    input  logic [79:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] az_drive, [17:9] el_drive, [18] halted, [31:19] current_azimuth,
    // [43:32] current_elevation, [47:44] zero
    output logic [47:0] m_tdata,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = tarrc_pkg::SPEED_W;
    localparam int AW = tarrc_pkg::ANGLE_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]         az_max_drive_reg;
    logic [7:0]         el_max_drive_reg;
    logic [15:0]        az_ramp_rate_reg;
    logic [15:0]        el_ramp_rate_reg;
    logic [11:0]        az_half_deadband_reg;
    logic [10:0]        el_half_deadband_reg;
    logic signed [7:0]  el_lower_limit_reg;
    logic signed [7:0]  el_upper_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_max_drive_reg     <= 8'd255;
            el_max_drive_reg     <= 8'd255;
            az_ramp_rate_reg     <= 16'd128;
            el_ramp_rate_reg     <= 16'd128;
            az_half_deadband_reg <= 12'd16;
            el_half_deadband_reg <= 11'd16;
            el_lower_limit_reg   <= 8'sd0;
            el_upper_limit_reg   <= 8'sd90;
        end else if (cfg_we) begin
            unique case (tarrc_pkg::reg_index_t'(cfg_index))
                tarrc_pkg::REG_AZ_MAX_DRIVE:     az_max_drive_reg     <= cfg_data[7:0];
                tarrc_pkg::REG_EL_MAX_DRIVE:     el_max_drive_reg     <= cfg_data[7:0];
                tarrc_pkg::REG_AZ_RAMP_RATE:     az_ramp_rate_reg     <= cfg_data;
                tarrc_pkg::REG_EL_RAMP_RATE:     el_ramp_rate_reg     <= cfg_data;
                tarrc_pkg::REG_AZ_HALF_DEADBAND: az_half_deadband_reg <= cfg_data[11:0];
                tarrc_pkg::REG_EL_HALF_DEADBAND: el_half_deadband_reg <= cfg_data[10:0];
                tarrc_pkg::REG_EL_LOWER_LIMIT:   el_lower_limit_reg   <= cfg_data[7:0];
                tarrc_pkg::REG_EL_UPPER_LIMIT:   el_upper_limit_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    tarrc_pkg::action_t    in_action_reg;
    logic signed [12:0]    in_maz_reg;
    logic signed [11:0]    in_mel_reg;
    logic [15:0]           in_ms_reg;
    logic signed [15:0]    in_waz_reg;
    logic signed [15:0]    in_wel_reg;
    logic                  adv;

    // adv moves the held input beat through the compute stage into the
    // output register; state is committed on the same edge.
    assign adv      = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= tarrc_pkg::action_t'(s_tuser);
            in_maz_reg    <= s_tdata[12:0];
            in_mel_reg    <= s_tdata[24:13];
            in_ms_reg     <= s_tdata[40:25];
            in_waz_reg    <= s_tdata[56:41];
            in_wel_reg    <= s_tdata[72:57];
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic signed [12:0]    goal_az_reg, goal_az_next;
    logic signed [11:0]    goal_el_reg, goal_el_next;
    logic                  goal_loaded_reg;
    logic signed [SW-1:0]  az_speed_reg, az_speed_next;
    logic signed [SW-1:0]  el_speed_reg, el_speed_next;
    logic                  movement_off_reg, movement_off_next;
    logic signed [12:0]    last_az_reg, last_az_next;
    logic signed [11:0]    last_el_reg, last_el_next;

    // The very first beat after reset seeds the goal from its measurement,
    // before the action itself is applied.
    logic signed [12:0]    goal_az_eff;
    logic signed [11:0]    goal_el_eff;
    assign goal_az_eff = goal_loaded_reg ? goal_az_reg : in_maz_reg;
    assign goal_el_eff = goal_loaded_reg ? goal_el_reg : in_mel_reg;

    // Set-target arithmetic: wrap azimuth, clamp elevation (upper, then lower
    // so the lower limit wins when the two are crossed), scale to 1/16 deg.
    logic signed [8:0]     waz_wrapped;
    logic signed [15:0]    wel_hi_clamped;
    logic signed [15:0]    wel_clamped;
    logic signed [7:0]     wel_deg;
    logic signed [12:0]    set_goal_az;
    logic signed [11:0]    set_goal_el;

    assign waz_wrapped    = tarrc_pkg::wrap_deg(in_waz_reg);
    assign wel_hi_clamped = (in_wel_reg > 16'(el_upper_limit_reg)) ?
                            16'(el_upper_limit_reg) : in_wel_reg;
    assign wel_clamped    = (wel_hi_clamped < 16'(el_lower_limit_reg)) ?
                            16'(el_lower_limit_reg) : wel_hi_clamped;
    assign wel_deg        = wel_clamped[7:0];
    assign set_goal_az    = 13'(waz_wrapped) <<< tarrc_pkg::ANGLE_FRACTION_BITS;
    assign set_goal_el    = 12'(wel_deg) <<< tarrc_pkg::ANGLE_FRACTION_BITS;

    // Per-axis deadband and ramp
    tarrc_pkg::axis_cfg_t  az_cfg;
    tarrc_pkg::axis_cfg_t  el_cfg;
    logic signed [SW-1:0]  az_ramped;
    logic signed [SW-1:0]  el_ramped;

    assign az_cfg = '{max_drive:     az_max_drive_reg,
                      ramp_rate:     az_ramp_rate_reg,
                      half_deadband: az_half_deadband_reg};
    assign el_cfg = '{max_drive:     el_max_drive_reg,
                      ramp_rate:     el_ramp_rate_reg,
                      half_deadband: 12'(el_half_deadband_reg)};

    tarrc_axis_ramp u_az_ramp (
        .movement_off (movement_off_reg),
        .cur_angle    (AW'(in_maz_reg)),
        .goal_angle   (AW'(goal_az_eff)),
        .elapsed_ms   (in_ms_reg),
        .cfg          (az_cfg),
        .speed        (az_speed_reg),
        .speed_next   (az_ramped)
    );

    // Elevation ramps at its own rate
    tarrc_axis_ramp u_el_ramp (
        .movement_off (movement_off_reg),
        .cur_angle    (AW'(in_mel_reg)),
        .goal_angle   (AW'(goal_el_eff)),
        .elapsed_ms   (in_ms_reg),
        .cfg          (el_cfg),
        .speed        (el_speed_reg),
        .speed_next   (el_ramped)
    );

    always_comb begin
        goal_az_next      = goal_az_eff;
        goal_el_next      = goal_el_eff;
        az_speed_next     = az_speed_reg;
        el_speed_next     = el_speed_reg;
        movement_off_next = movement_off_reg;
        last_az_next      = in_maz_reg;
        last_el_next      = in_mel_reg;
        unique case (in_action_reg)
            tarrc_pkg::ACT_SET: begin
                // Measurement is ignored: keep the last one reported
                goal_az_next      = set_goal_az;
                goal_el_next      = set_goal_el;
                movement_off_next = 1'b0;
                last_az_next      = last_az_reg;
                last_el_next      = last_el_reg;
            end
            tarrc_pkg::ACT_TICK: begin
                az_speed_next = az_ramped;
                el_speed_next = el_ramped;
            end
            tarrc_pkg::ACT_STOP: begin
                goal_az_next = in_maz_reg;
                goal_el_next = in_mel_reg;
            end
            tarrc_pkg::ACT_ESTOP: begin
                goal_az_next      = in_maz_reg;
                goal_el_next      = in_mel_reg;
                az_speed_next     = '0;
                el_speed_next     = '0;
                movement_off_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_az_reg      <= '0;
            goal_el_reg      <= '0;
            goal_loaded_reg  <= 1'b0;
            az_speed_reg     <= '0;
            el_speed_reg     <= '0;
            movement_off_reg <= 1'b0;
            last_az_reg      <= '0;
            last_el_reg      <= '0;
        end else if (adv) begin
            goal_az_reg      <= goal_az_next;
            goal_el_reg      <= goal_el_next;
            goal_loaded_reg  <= 1'b1;
            az_speed_reg     <= az_speed_next;
            el_speed_reg     <= el_speed_next;
            movement_off_reg <= movement_off_next;
            last_az_reg      <= last_az_next;
            last_el_reg      <= last_el_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: drive is speed truncated toward zero
    // ------------------------------------------------------------------
    function automatic logic signed [8:0] to_drive(input logic signed [SW-1:0] spd);
        logic [SW:0] mag;
        logic [8:0]  mag_d;
        mag   = (spd < 0) ? (SW+1)'(-(SW+1)'(spd)) : (SW+1)'(spd);
        mag_d = 9'(mag >> tarrc_pkg::FRACTION_BITS);
        return (spd < 0) ? -$signed(mag_d) : $signed(mag_d);
    endfunction

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {4'b0000,
                            last_el_next,
                            last_az_next,
                            movement_off_next,
                            to_drive(el_speed_next),
                            to_drive(az_speed_next)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_estop_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_action_reg == tarrc_pkg::ACT_ESTOP) |=>
            (m_tvalid && m_tdata[18] && m_tdata[17:0] == 18'd0))
        else $error("emergency stop did not zero drives and halt");

    a_set_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_action_reg == tarrc_pkg::ACT_SET) |=> !movement_off_reg)
        else $error("set target did not re-enable movement");

    a_speed_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(az_speed_reg) && $stable(el_speed_reg)))
        else $error("speed changed without an item");

    a_goal_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(goal_loaded_reg) |-> $past(adv))
        else $error("goal loaded without an item");

    a_out_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !adv) |=> m_tvalid)
        else $error("stalled result dropped");

endmodule
